// ===== rtl/lpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpcr_pkg
// Shared constants, report codes and the byte-wide crc-16 ccitt update.
// ----------------------------------------------------------------------------
package lpcr_pkg;

  localparam logic [7:0]  StartByte      = 8'h80;
  localparam logic [15:0] CrcInit        = 16'hFFFF;
  localparam logic [15:0] MaxPayloadRst  = 16'd256;

  typedef enum logic [1:0] {
    STATUS_GOOD      = 2'd0,
    STATUS_BAD_START = 2'd1,
    STATUS_LEN_ERR   = 2'd2,
    STATUS_CRC_ERR   = 2'd3
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_e;

  // crc-16 ccitt, poly 0x1021, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'h0, x[7:4]};
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

// ===== rtl/length_prefixed_crc_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_crc_frame_receiver
// Parses start byte, length, payload and crc of a response frame and emits
// payload bytes with their index plus end and error reports.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-------------------------------
//  rx        | in        | in_valid_i / in_stall_o | rx_byte_i
//  report    | out       | out_valid_o/ out_stall_i| report_kind_o .. frame_length_o
//  config    | in        | cfg_wr_en_i             | cfg_wr_data_i (max payload)
//
//  one byte per cycle sustained while the report side does not stall; a byte
//  lands in the input register, and the parser step and crc update carry it
//  into the result register, which drives out_valid_o and the report fields
//  a stall on the report side backs up into in_stall_o once both registers hold
//  reset returns to hunting with crc 0xffff and a payload limit of 256
// ----------------------------------------------------------------------------
module length_prefixed_crc_frame_receiver
  import lpcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        report_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] byte_index_o,
  output logic [1:0]  frame_status_o,
  output logic [15:0] frame_length_o,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC_LO  = 3'd4,
    PH_CRC_HI  = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] exp_len_q, exp_len_d;
  logic [15:0] rx_cnt_q, rx_cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] max_payload_q;

  logic        in_valid_q;
  logic [7:0]  byte_q;

  logic        out_valid_q;
  logic        kind_q, kind_d;
  logic [7:0]  pbyte_q, pbyte_d;
  logic [15:0] index_q, index_d;
  logic [1:0]  status_q, status_d;
  logic [15:0] length_q, length_d;
  logic        res_valid_d;

  logic        advance;
  logic [15:0] hdr_len;
  logic [15:0] cnt_inc;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign hdr_len    = {byte_q, exp_len_q[7:0]};
  assign cnt_inc    = rx_cnt_q + 16'd1;

  always_comb begin
    phase_d     = phase_q;
    exp_len_d   = exp_len_q;
    rx_cnt_d    = rx_cnt_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    res_valid_d = 1'b0;
    kind_d      = KIND_REPORT;
    pbyte_d     = 8'h00;
    index_d     = 16'h0000;
    status_d    = STATUS_GOOD;
    length_d    = 16'h0000;
    unique case (phase_q)
      PH_LEN_LO: begin
        exp_len_d = {8'h00, byte_q};
        phase_d   = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        exp_len_d = hdr_len;
        if (hdr_len > max_payload_q) begin
          res_valid_d = 1'b1;
          status_d    = STATUS_LEN_ERR;
          length_d    = hdr_len;
          phase_d     = PH_HUNT;
        end else begin
          phase_d = (hdr_len == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_d       = crc16_byte(crc_q, byte_q);
        res_valid_d = 1'b1;
        kind_d      = KIND_PAYLOAD;
        pbyte_d     = byte_q;
        index_d     = rx_cnt_q;
        rx_cnt_d    = cnt_inc;
        if (cnt_inc == exp_len_q) begin
          phase_d = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_d = byte_q;
        phase_d  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        res_valid_d = 1'b1;
        status_d    = ({byte_q, crc_lo_q} == crc_q) ? STATUS_GOOD : STATUS_CRC_ERR;
        length_d    = exp_len_q;
        phase_d     = PH_HUNT;
      end
      default: begin
        if (byte_q == StartByte) begin
          phase_d   = PH_LEN_LO;
          crc_d     = CrcInit;
          rx_cnt_d  = 16'h0000;
          exp_len_d = 16'h0000;
        end else begin
          res_valid_d = 1'b1;
          status_d    = STATUS_BAD_START;
          phase_d     = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HUNT;
      exp_len_q     <= 16'h0000;
      rx_cnt_q      <= 16'h0000;
      crc_q         <= CrcInit;
      crc_lo_q      <= 8'h00;
      max_payload_q <= MaxPayloadRst;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        max_payload_q <= cfg_wr_data_i;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        phase_q   <= phase_d;
        exp_len_q <= exp_len_d;
        rx_cnt_q  <= rx_cnt_d;
        crc_q     <= crc_d;
        crc_lo_q  <= crc_lo_d;
      end
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= advance && res_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
    if (advance && res_valid_d) begin
      kind_q   <= kind_d;
      pbyte_q  <= pbyte_d;
      index_q  <= index_d;
      status_q <= status_d;
      length_q <= length_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign report_kind_o  = kind_q;
  assign payload_byte_o = pbyte_q;
  assign byte_index_o   = index_q;
  assign frame_status_o = status_q;
  assign frame_length_o = length_q;

endmodule

// ===== rtl/lpcr_checker.sv =====
// ----------------------------------------------------------------------------
// lpcr_checker
// Port-level checks on the report channel of the frame receiver.
// ----------------------------------------------------------------------------
module lpcr_checker
  import lpcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        report_kind_o,
  input  logic [7:0]  payload_byte_o,
  input  logic [15:0] byte_index_o,
  input  logic [1:0]  frame_status_o,
  input  logic [15:0] frame_length_o
);

  // a stalled request stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("report dropped while stalled");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_kind_o == KIND_PAYLOAD |->
      frame_status_o == STATUS_GOOD && frame_length_o == 16'h0000)
    else $error("payload request carries report fields");

  a_report_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_kind_o == KIND_REPORT |->
      payload_byte_o == 8'h00 && byte_index_o == 16'h0000)
    else $error("report carries payload fields");

  a_bad_start_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_kind_o == KIND_REPORT && frame_status_o == STATUS_BAD_START
      |-> frame_length_o == 16'h0000)
    else $error("bad start report with length");

  a_len_err_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_kind_o == KIND_REPORT && frame_status_o == STATUS_LEN_ERR
      |-> frame_length_o != 16'h0000)
    else $error("length error with zero length");

endmodule

bind length_prefixed_crc_frame_receiver lpcr_checker u_lpcr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .report_kind_o  (report_kind_o),
  .payload_byte_o (payload_byte_o),
  .byte_index_o   (byte_index_o),
  .frame_status_o (frame_status_o),
  .frame_length_o (frame_length_o)
);
